/* hdl/pms_pkg.sv */
// ----------------------------------------------------------------------------
// pms_pkg
// shared types, constants and a helper function of the message scheduler
// ----------------------------------------------------------------------------
package pms_pkg;

    localparam int SLOTS    = 8;
    localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int IDX_W    = SLOT_W + 1;
    localparam int WALK_MAX = (SLOTS < 8) ? SLOTS : 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_SLOTS  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_BEACON_PERIOD = CFG_IDX_W'(1);

    localparam logic [3:0]  ACTIVE_SLOTS_RST  = 4'd0;
    localparam logic [15:0] BEACON_PERIOD_RST = 16'd1000;

    localparam logic [15:0] DISABLED_INTERVAL = 16'hFFFF;
    localparam logic [15:0] ELAPSED_MAX       = 16'hFFFF;
    localparam logic [7:0]  NO_SECTION        = 8'hFF;

    localparam logic [1:0] ACT_TICK    = 2'd0;
    localparam logic [1:0] ACT_LOAD    = 2'd1;
    localparam logic [1:0] ACT_ONESHOT = 2'd2;

    localparam logic [1:0] KIND_PERIODIC = 2'd0;
    localparam logic [1:0] KIND_ONESHOT  = 2'd1;
    localparam logic [1:0] KIND_BEACON   = 2'd2;

    typedef struct packed {
        logic [1:0]  action;
        logic [2:0]  slot;
        logic [15:0] interval;
        logic [7:0]  oneshot_section;
    } t_in_item;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] section;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic [3:0]  active_slots;
        logic [15:0] beacon_period;
    } t_cfg;

    typedef struct packed {
        logic [15:0] reload;
        logic [15:0] count;
    } t_entry;

    localparam t_entry ENTRY_RST = '{reload: DISABLED_INTERVAL, count: 16'd0};

    typedef struct packed {
        logic              rd_en;
        logic [SLOT_W-1:0] rd_addr;
        logic              wr_en;
        logic [SLOT_W-1:0] wr_addr;
        t_entry            wr_data;
    } t_tbl_req;

    // (interval - slot) mod interval, remainder signed like the dividend
    function automatic logic [15:0] f_stagger(input logic [15:0] interval,
                                              input logic [2:0]  slot);
        logic [2:0] div;
        logic [2:0] rem;
        f_stagger = 16'd0;
        div = interval[2:0];
        rem = slot - div;
        if (interval == 16'd0 || slot == 3'd0) begin
            f_stagger = 16'd0;
        end else if (interval >= {13'd0, slot}) begin
            f_stagger = interval - {13'd0, slot};
        end else begin
            for (int k = 0; k < 7; k++) begin
                if (rem >= div) begin
                    rem = rem - div;
                end
            end
            f_stagger = 16'd0 - {13'd0, rem};
        end
    endfunction

endpackage

/* hdl/pms_table.sv */
// ----------------------------------------------------------------------------
// pms_table
// slot table memory holding reload interval and countdown per slot
// ----------------------------------------------------------------------------
module pms_table
    import pms_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_tbl_req i_req,
    output t_entry   o_rdata
);

    logic [$bits(t_entry)-1:0] mem [SLOTS];
    logic [SLOTS-1:0]          r_written;
    logic [$bits(t_entry)-1:0] r_rd_data;
    logic                      r_rd_written;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= mem[i_req.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written    <= '0;
            r_rd_written <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_written[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_written <= r_written[i_req.rd_addr];
            end
        end
    end

    // unwritten entries read as disabled slots
    assign o_rdata = r_rd_written ? t_entry'(r_rd_data) : ENTRY_RST;

endmodule

/* hdl/pms_ctrl.sv */
// ----------------------------------------------------------------------------
// pms_ctrl
// item sequencer: slot walk, one-shot and beacon checks, result output stage
// ----------------------------------------------------------------------------
module pms_ctrl
    import pms_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_in_valid,
    input  t_in_item  i_in_data,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_item o_out_data,
    input  logic      i_out_stall,
    output t_tbl_req  o_tbl_req,
    input  t_entry    i_tbl_rdata
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_WALK   = 5'b00010,
        S_PEND   = 5'b00100,
        S_BEACON = 5'b01000,
        S_FLUSH  = 5'b10000
    } t_state;

    t_state      r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [IDX_W-1:0] r_walk, n_walk;
    logic [7:0]  r_pending, n_pending;
    logic [15:0] r_elapsed, n_elapsed;
    t_out_item   r_hold, n_hold;
    logic        r_hold_valid, n_hold_valid;
    t_out_item   r_out, n_out;
    logic        r_out_valid, n_out_valid;

    logic             disabled;
    logic [15:0]      new_count;
    logic [15:0]      elapsed_inc;
    logic             produce;
    t_out_item        res;
    logic             can_push;
    logic             step_ok;
    logic [IDX_W-1:0] idx_inc;

    assign disabled    = (i_tbl_rdata.reload == DISABLED_INTERVAL);
    assign new_count   = (i_tbl_rdata.count != 16'd0) ? i_tbl_rdata.count - 16'd1
                                                      : i_tbl_rdata.reload - 16'd1;
    assign elapsed_inc = (r_elapsed == ELAPSED_MAX) ? r_elapsed : r_elapsed + 16'd1;
    assign idx_inc     = r_idx + IDX_W'(1);
    assign can_push    = !r_out_valid || !i_out_stall;
    assign step_ok     = !produce || !r_hold_valid || can_push;

    // result produced by the current step
    always_comb begin
        produce = 1'b0;
        res     = '0;
        unique case (r_state)
            S_WALK: begin
                produce     = !disabled && (i_tbl_rdata.count == 16'd0);
                res.kind    = KIND_PERIODIC;
                res.section = 8'(r_idx[SLOT_W-1:0]);
            end
            S_PEND: begin
                produce     = (r_pending != NO_SECTION);
                res.kind    = KIND_ONESHOT;
                res.section = r_pending;
            end
            S_BEACON: begin
                produce     = (elapsed_inc > i_cfg.beacon_period);
                res.kind    = KIND_BEACON;
                res.section = 8'd0;
            end
            default: begin
                produce = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_walk       = r_walk;
        n_pending    = r_pending;
        n_elapsed    = r_elapsed;
        n_hold       = r_hold;
        n_hold_valid = r_hold_valid;
        n_out        = r_out;
        n_out_valid  = r_out_valid && i_out_stall;
        o_tbl_req    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_in_data.action)
                        ACT_TICK: begin
                            n_idx  = '0;
                            n_walk = (32'(i_cfg.active_slots) > WALK_MAX)
                                     ? IDX_W'(WALK_MAX) : IDX_W'(i_cfg.active_slots);
                            if (n_walk == '0) begin
                                n_state = S_PEND;
                            end else begin
                                o_tbl_req.rd_en   = 1'b1;
                                o_tbl_req.rd_addr = '0;
                                n_state           = S_WALK;
                            end
                        end
                        ACT_LOAD: begin
                            if (32'(i_in_data.slot) < SLOTS) begin
                                o_tbl_req.wr_en   = 1'b1;
                                o_tbl_req.wr_addr = SLOT_W'(i_in_data.slot);
                                o_tbl_req.wr_data.reload = i_in_data.interval;
                                o_tbl_req.wr_data.count  =
                                    f_stagger(i_in_data.interval, i_in_data.slot);
                            end
                        end
                        ACT_ONESHOT: begin
                            if (r_pending == NO_SECTION) begin
                                n_pending = i_in_data.oneshot_section;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_WALK: begin
                if (step_ok) begin
                    o_tbl_req.wr_en          = !disabled;
                    o_tbl_req.wr_addr        = r_idx[SLOT_W-1:0];
                    o_tbl_req.wr_data.reload = i_tbl_rdata.reload;
                    o_tbl_req.wr_data.count  = new_count;
                    n_idx                    = idx_inc;
                    if (idx_inc == r_walk) begin
                        n_state = S_PEND;
                    end else begin
                        o_tbl_req.rd_en   = 1'b1;
                        o_tbl_req.rd_addr = idx_inc[SLOT_W-1:0];
                    end
                end
            end
            S_PEND: begin
                if (step_ok) begin
                    n_pending = NO_SECTION;
                    n_state   = S_BEACON;
                end
            end
            S_BEACON: begin
                if (step_ok) begin
                    n_elapsed = produce ? 16'd0 : elapsed_inc;
                    n_state   = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (!r_hold_valid) begin
                    n_state = S_IDLE;
                end else if (can_push) begin
                    n_out        = r_hold;
                    n_out.last   = 1'b1;
                    n_out_valid  = 1'b1;
                    n_hold_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // one result is held back so the final one can be marked
        if (step_ok && produce) begin
            if (r_hold_valid) begin
                n_out       = r_hold;
                n_out.last  = 1'b0;
                n_out_valid = 1'b1;
            end
            n_hold       = res;
            n_hold_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pending    <= NO_SECTION;
            r_elapsed    <= 16'd0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_pending    <= n_pending;
            r_elapsed    <= n_elapsed;
            r_hold_valid <= n_hold_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_walk <= n_walk;
        r_hold <= n_hold;
        r_out  <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

/* hdl/periodic_message_scheduler_unit.sv */
// ----------------------------------------------------------------------------
// periodic_message_scheduler_unit
// per-slot reload counters walked on each tick, one-shot section and beacon
// ----------------------------------------------------------------------------
// input channel: i_in_valid / o_in_stall with i_in_data; a tick walks the
//   active slots, a load writes a slot interval, a one-shot request latches
//   a section; load and one-shot transfers give no result
// output channel: o_out_valid / i_out_stall with o_out_data; a tick gives
//   zero to ten results, last marks the final one of the tick
// config channel: i_cfg_valid / o_cfg_ready with i_cfg_index, i_cfg_data;
//   ready is always high; writes are to be made while the block is idle,
//   which the block itself does not enforce
// a tick walks the active slots (walk = active slots, at most 8), one slot per
//   cycle by the table read-modify-write while no output stall holds it; each
//   result waits in a hold register for the next one or the tick end
// stall on the output holds the result register and pauses the walk
// reset: slots disabled, counters zero, nothing pending, beacon count zero,
//   active slots 0, beacon period 1000; no clearing pass is needed
// ----------------------------------------------------------------------------
module periodic_message_scheduler_unit
    import pms_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  t_in_item              i_in_data,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    output t_out_item             o_out_data,
    input  logic                  i_out_stall,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [3:0]  r_active_slots;
    logic [15:0] r_beacon_period;
    t_cfg        cfg;
    t_tbl_req    tbl_req;
    t_entry      tbl_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_slots  <= ACTIVE_SLOTS_RST;
            r_beacon_period <= BEACON_PERIOD_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_ACTIVE_SLOTS:  r_active_slots  <= i_cfg_data[3:0];
                REG_BEACON_PERIOD: r_beacon_period <= i_cfg_data[15:0];
                default: begin
                    r_active_slots <= r_active_slots;
                end
            endcase
        end
    end

    assign o_cfg_ready       = 1'b1;
    assign cfg.active_slots  = r_active_slots;
    assign cfg.beacon_period = r_beacon_period;

    pms_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall),
        .o_tbl_req   (tbl_req),
        .i_tbl_rdata (tbl_rdata)
    );

    pms_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (tbl_req),
        .o_rdata (tbl_rdata)
    );

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the periodic message scheduler: slot loads, one-shot
// requests and ticks are sent, directed and then in random bursts, while the result side stalls on
// its own pattern; every result is checked against an in-bench schedule model
// ----------------------------------------------------------------------------
module tb_top
    import pms_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0]           ACT_UNUSED   = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = CFG_IDX_W'(3);
    localparam int                   SETTLE       = 32;
    localparam int                   HOLD_CYCLES  = 400;

    class slot_schedule_board;
        logic [15:0] reload_tab [SLOTS];
        logic [15:0] count_tab [SLOTS];
        logic [7:0]  pending;
        logic [15:0] elapsed;
        logic [3:0]  active_cfg;
        logic [15:0] period_cfg;
        t_out_item   due_results [$];
        int          errors;

        function new();
            foreach (reload_tab[i]) begin
                reload_tab[i] = DISABLED_INTERVAL;
                count_tab[i]  = 16'd0;
            end
            pending    = NO_SECTION;
            elapsed    = 16'd0;
            active_cfg = ACTIVE_SLOTS_RST;
            period_cfg = BEACON_PERIOD_RST;
            errors     = 0;
        endfunction

        function void apply_register(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
            if (idx == REG_ACTIVE_SLOTS) begin
                active_cfg = data[3:0];
            end else if (idx == REG_BEACON_PERIOD) begin
                period_cfg = data;
            end
        endfunction

        // (interval - slot) mod interval, negative remainder wraps to 16 bits
        function logic [15:0] stagger_count(logic [15:0] iv, logic [2:0] s);
            int unsigned mag;
            if (iv == 16'd0) begin
                return 16'd0;
            end
            if (32'(iv) >= 32'(s)) begin
                return 16'((32'(iv) - 32'(s)) % 32'(iv));
            end
            mag = (32'(s) - 32'(iv)) % 32'(iv);
            return 16'(32'h10000 - mag);
        endfunction

        function void note_item(t_in_item it);
            t_out_item batch [$];
            t_out_item r;
            int        walk;
            case (it.action)
                ACT_LOAD: begin
                    if (int'(it.slot) < SLOTS) begin
                        reload_tab[it.slot] = it.interval;
                        count_tab[it.slot]  = stagger_count(it.interval, it.slot);
                    end
                end
                ACT_ONESHOT: begin
                    if (pending == NO_SECTION) begin
                        pending = it.oneshot_section;
                    end
                end
                ACT_TICK: begin
                    walk = int'(active_cfg);
                    if (walk > SLOTS) begin
                        walk = SLOTS;
                    end
                    if (walk > WALK_MAX) begin
                        walk = WALK_MAX;
                    end
                    for (int i = 0; i < walk; i++) begin
                        if (reload_tab[i] != DISABLED_INTERVAL) begin
                            if (count_tab[i] != 16'd0) begin
                                count_tab[i] = count_tab[i] - 16'd1;
                            end else begin
                                count_tab[i] = reload_tab[i] - 16'd1;
                                r.kind    = KIND_PERIODIC;
                                r.section = 8'(i);
                                r.last    = 1'b0;
                                batch.push_back(r);
                            end
                        end
                    end
                    if (pending != NO_SECTION) begin
                        r.kind    = KIND_ONESHOT;
                        r.section = pending;
                        r.last    = 1'b0;
                        batch.push_back(r);
                        pending = NO_SECTION;
                    end
                    if (elapsed != ELAPSED_MAX) begin
                        elapsed = elapsed + 16'd1;
                    end
                    if (elapsed > period_cfg) begin
                        elapsed   = 16'd0;
                        r.kind    = KIND_BEACON;
                        r.section = 8'd0;
                        r.last    = 1'b0;
                        batch.push_back(r);
                    end
                    foreach (batch[k]) begin
                        r      = batch[k];
                        r.last = (k == batch.size() - 1);
                        due_results.push_back(r);
                    end
                end
                default: begin
                end
            endcase
        endfunction

        task report_mismatch(string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            errors++;
        endtask

        task check_result(t_out_item got);
            t_out_item want;
            if (due_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind=%0d section=%0d last=%0d",
                                          got.kind, got.section, got.last));
                return;
            end
            want = due_results.pop_front();
            if (got.kind !== want.kind) begin
                report_mismatch($sformatf("kind got %0d want %0d", got.kind, want.kind));
            end
            if (got.section !== want.section) begin
                report_mismatch($sformatf("section got %0d want %0d",
                                          got.section, want.section));
            end
            if (got.last !== want.last) begin
                report_mismatch($sformatf("last got %0d want %0d", got.last, want.last));
            end
        endtask
    endclass

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    t_in_item              i_in_data   = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    t_out_item             o_out_data;
    logic                  i_out_stall = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    slot_schedule_board sb = new();
    bit                 hold_req = 1'b0;

    periodic_message_scheduler_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result(o_out_data);
        end
    end

    function automatic t_in_item make_item(logic [1:0] action, logic [2:0] slot,
                                           logic [15:0] interval, logic [7:0] sec);
        t_in_item it;
        it                 = t_in_item'(29'($urandom));
        it.action          = action;
        it.slot            = slot;
        it.interval        = interval;
        it.oneshot_section = sec;
        return it;
    endfunction

    function automatic logic [15:0] pick_interval();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            return 16'd0;
        end else if (r < 14) begin
            return DISABLED_INTERVAL;
        end else if (r < 18) begin
            return 16'hFFFE;
        end else if (r < 24) begin
            return 16'($urandom);
        end
        return 16'($urandom_range(1, 12));
    endfunction

    function automatic t_in_item random_item();
        t_in_item it;
        int       r;
        it = t_in_item'(29'($urandom));
        r  = $urandom_range(0, 99);
        if (r < 45) begin
            it.action = ACT_TICK;
        end else if (r < 75) begin
            it.action   = ACT_LOAD;
            it.interval = pick_interval();
        end else if (r < 92) begin
            it.action = ACT_ONESHOT;
            if ($urandom_range(0, 9) == 0) begin
                it.oneshot_section = NO_SECTION;
            end
        end else begin
            it.action = ACT_UNUSED;
        end
        return it;
    endfunction

    task automatic send_item(t_in_item it);
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        sb.note_item(it);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        sb.apply_register(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.due_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // result side: segments of free flow, light and heavy stall, plus one long hold
    initial begin
        int seg_left;
        int mode;
        seg_left = 0;
        mode     = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                if (seg_left == 0) begin
                    seg_left = $urandom_range(10, 120);
                    mode     = $urandom_range(0, 2);
                end
                seg_left--;
                case (mode)
                    0: i_out_stall <= 1'b0;
                    1: i_out_stall <= 1'($urandom_range(0, 1));
                    default: i_out_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        logic [3:0]  active_set [8];
        logic [15:0] period_set [8];
        int sent;
        int len;
        int gap;

        active_set = '{4'd8, 4'd0, 4'd15, 4'd9, 4'd3, 4'd1, 4'd8, 4'd5};
        period_set = '{16'd65535, 16'd0, 16'd3, 16'd1, 16'd1000, 16'd7, 16'd2, 16'd20};

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part: stagger corners, disabled slot, one-shot rules, beacon every tick
        write_register(REG_ACTIVE_SLOTS, 16'd8);
        write_register(REG_BEACON_PERIOD, 16'd0);
        write_register(REG_UNMAPPED, 16'hFFFF);
        send_item(make_item(ACT_TICK, 3'd0, 16'd0, 8'd0));
        send_item(make_item(ACT_LOAD, 3'd0, 16'd0, 8'd0));
        send_item(make_item(ACT_LOAD, 3'd1, 16'd1, 8'd0));
        send_item(make_item(ACT_LOAD, 3'd2, DISABLED_INTERVAL, 8'd0));
        send_item(make_item(ACT_LOAD, 3'd3, 16'd2, 8'd0));
        send_item(make_item(ACT_LOAD, 3'd4, 16'd3, 8'd0));
        send_item(make_item(ACT_LOAD, 3'd5, 16'd3, 8'd0));
        send_item(make_item(ACT_LOAD, 3'd6, 16'd6, 8'd0));
        send_item(make_item(ACT_LOAD, 3'd7, 16'hFFFE, 8'd0));
        send_item(make_item(ACT_ONESHOT, 3'd0, 16'd0, 8'd0));
        send_item(make_item(ACT_ONESHOT, 3'd7, 16'hFFFF, 8'd254));
        send_item(make_item(ACT_TICK, 3'd7, 16'hFFFF, 8'd255));
        send_item(make_item(ACT_ONESHOT, 3'd0, 16'd0, NO_SECTION));
        send_item(make_item(ACT_TICK, 3'd0, 16'd0, 8'd0));
        send_item(make_item(ACT_UNUSED, 3'd7, 16'hFFFF, 8'hFF));
        send_item(make_item(ACT_ONESHOT, 3'd2, 16'h5555, 8'hAA));
        repeat (4) send_item(make_item(ACT_TICK, 3'd5, 16'hAAAA, 8'h55));
        send_item(make_item(ACT_LOAD, 3'd7, 16'd1, 8'd0));
        send_item(make_item(ACT_TICK, 3'd0, 16'd0, 8'd0));
        drain();
        write_register(REG_ACTIVE_SLOTS, 16'hFFF8);
        write_register(REG_BEACON_PERIOD, 16'd65535);
        repeat (3) send_item(make_item(ACT_TICK, 3'd0, 16'd0, 8'd0));

        // random part, one configuration per phase
        for (int ph = 0; ph < 8; ph++) begin
            drain();
            write_register(REG_ACTIVE_SLOTS, {12'($urandom), active_set[ph]});
            write_register(REG_BEACON_PERIOD, period_set[ph]);
            if (ph == 2) begin
                hold_req = 1'b1;
            end
            sent = 0;
            while (sent < 60) begin
                len = $urandom_range(1, 16);
                if (len > 60 - sent) begin
                    len = 60 - sent;
                end
                for (int k = 0; k < len; k++) begin
                    send_item(random_item());
                    sent++;
                end
                gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 15);
                if (gap > 0) begin
                    i_in_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end

        drain();
        if (sb.due_results.size() != 0) begin
            sb.report_mismatch("results still outstanding at end of run");
        end
        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* sim.f */
hdl/pms_pkg.sv
hdl/pms_table.sv
hdl/pms_ctrl.sv
hdl/periodic_message_scheduler_unit.sv
verif/tb_top.sv
